### hw/rtl/integer_xo_alu_assert.svh
// ----------------------------------------------------------------------------
// integer_xo_alu_assert
// assertion macros for the xo alu
// ----------------------------------------------------------------------------
`ifndef INTEGER_XO_ALU_ASSERT_SVH
`define INTEGER_XO_ALU_ASSERT_SVH
`ifndef SYNTH
`define XO_ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("xo alu check failed");
`define XO_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("xo alu check failed");
`else
`define XO_ASSERT_IMP(label, clk, rst_n, a, c)
`define XO_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

### hw/rtl/ixa_pkg.sv
// ----------------------------------------------------------------------------
// ixa_pkg
// shared types and opcode constants for the xo-form integer alu
// ----------------------------------------------------------------------------
package ixa_pkg;
	localparam logic [8:0] OP_ADD    = 9'd266;
	localparam logic [8:0] OP_ADDC   = 9'd10;
	localparam logic [8:0] OP_ADDE   = 9'd138;
	localparam logic [8:0] OP_ADDME  = 9'd234;
	localparam logic [8:0] OP_ADDZE  = 9'd202;
	localparam logic [8:0] OP_SUBF   = 9'd40;
	localparam logic [8:0] OP_SUBFC  = 9'd8;
	localparam logic [8:0] OP_SUBFE  = 9'd136;
	localparam logic [8:0] OP_SUBFME = 9'd232;
	localparam logic [8:0] OP_SUBFZE = 9'd200;
	localparam logic [8:0] OP_NEG    = 9'd104;
	localparam logic [8:0] OP_MULLW  = 9'd235;
	localparam logic [8:0] OP_MULHW  = 9'd75;
	localparam logic [8:0] OP_MULHWU = 9'd11;
	localparam logic [8:0] OP_DIVW   = 9'd491;
	localparam logic [8:0] OP_DIVWU  = 9'd459;
	localparam int DivSteps = 32;

	typedef enum logic [2:0] {
		ST_IDLE, ST_MUL, ST_DIV, ST_FIN, ST_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic mul;
		logic div_init;
		logic div_step;
		logic finish;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_mul;
		logic is_div;
	} stat_t;
endpackage

### hw/rtl/ixa_ctrl.sv
// ----------------------------------------------------------------------------
// ixa_ctrl
// sequencer for the xo alu: load, multiply or divide iterations, finish, output
// ----------------------------------------------------------------------------
module ixa_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  ixa_pkg::stat_t  stat,
	output ixa_pkg::cmd_t   cmd
);
	ixa_pkg::state_t state_q, state_d;
	logic [5:0] cnt_q, cnt_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ixa_pkg::ST_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ixa_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = ixa_pkg::ST_MUL;
				end
			end
			ixa_pkg::ST_MUL: begin
				// latched opcode now decoded
				cnt_d = '0;
				if (stat.is_div) begin
					cmd.div_init = 1'b1;
					state_d = ixa_pkg::ST_DIV;
				end else if (stat.is_mul) begin
					cmd.mul = 1'b1;
					state_d = ixa_pkg::ST_FIN;
				end else state_d = ixa_pkg::ST_FIN;
			end
			ixa_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d = cnt_q + 6'd1;
				if (cnt_q == 6'(ixa_pkg::DivSteps - 1)) state_d = ixa_pkg::ST_FIN;
			end
			ixa_pkg::ST_FIN: begin
				cmd.finish = 1'b1;
				state_d = ixa_pkg::ST_OUT;
			end
			ixa_pkg::ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) state_d = ixa_pkg::ST_IDLE;
			end
			default: state_d = ixa_pkg::ST_IDLE;
		endcase
	end
endmodule

### hw/rtl/ixa_dp.sv
// ----------------------------------------------------------------------------
// ixa_dp
// datapath: operand latch, adder, multiplier, restoring divider, flag state
// ----------------------------------------------------------------------------
module ixa_dp (
	input  logic           clk,
	input  logic           arst_n,
	input  ixa_pkg::cmd_t  cmd,
	output ixa_pkg::stat_t stat,
	input  logic [8:0]     op,
	input  logic [31:0]    a_value,
	input  logic [31:0]    b_value,
	input  logic           oe,
	input  logic           rc,
	output logic [31:0]    result,
	output logic           write_valid,
	output logic           carry_out,
	output logic           overflow_out,
	output logic           summary_out,
	output logic [3:0]     cr0_value,
	output logic           cr0_valid,
	output logic           illegal
);
	logic [8:0]  op_q;
	logic [31:0] a_q, b_q;
	logic        oe_q, rc_q;
	logic        ca_q, ov_q, so_q;
	logic [63:0] prod_q;
	logic [31:0] quo_q, rem_q, dvd_q;
	logic        is_add, is_sub, is_divw, is_divwu, legal;

	// operand latch
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= op; a_q <= a_value; b_q <= b_value; oe_q <= oe; rc_q <= rc;
		end
	end

	// decode
	always_comb begin
		is_add = (op_q == ixa_pkg::OP_ADD) || (op_q == ixa_pkg::OP_ADDC) ||
			(op_q == ixa_pkg::OP_ADDE) || (op_q == ixa_pkg::OP_ADDME) ||
			(op_q == ixa_pkg::OP_ADDZE);
		is_sub = (op_q == ixa_pkg::OP_SUBF) || (op_q == ixa_pkg::OP_SUBFC) ||
			(op_q == ixa_pkg::OP_SUBFE) || (op_q == ixa_pkg::OP_SUBFME) ||
			(op_q == ixa_pkg::OP_SUBFZE);
		is_divw = op_q == ixa_pkg::OP_DIVW;
		is_divwu = op_q == ixa_pkg::OP_DIVWU;
		stat.is_div = is_divw || is_divwu;
		stat.is_mul = (op_q == ixa_pkg::OP_MULLW) || (op_q == ixa_pkg::OP_MULHW) ||
			(op_q == ixa_pkg::OP_MULHWU);
		legal = is_add || is_sub || stat.is_div || stat.is_mul ||
			(op_q == ixa_pkg::OP_NEG);
	end

	// divider magnitudes
	logic sgn_div, neg_q;
	logic [31:0] abs_a, abs_b;
	assign sgn_div = is_divw;
	assign abs_a = (sgn_div && a_q[31]) ? 32'(-a_q) : a_q;
	assign abs_b = (sgn_div && b_q[31]) ? 32'(-b_q) : b_q;

	// one restoring divide step per cycle
	logic [32:0] trial;
	assign trial = {rem_q, dvd_q[31]} - {1'b0, abs_b};

	// 33x33 signed multiplier, top bit zero for the unsigned form
	logic [32:0] mul_a, mul_b;
	logic [65:0] mul_p;
	assign mul_a = {(op_q != ixa_pkg::OP_MULHWU) && a_q[31], a_q};
	assign mul_b = {(op_q != ixa_pkg::OP_MULHWU) && b_q[31], b_q};
	assign mul_p = $signed(mul_a) * $signed(mul_b);

	// multiply and divide registers
	always_ff @(posedge clk) begin
		if (cmd.mul) prod_q <= mul_p[63:0];
		if (cmd.load) begin
			rem_q <= '0;
			quo_q <= '0;
		end
		if (cmd.div_init) begin
			dvd_q <= abs_a;
			neg_q <= sgn_div && (a_q[31] ^ b_q[31]);
		end
		if (cmd.div_step) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], dvd_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
			dvd_q <= {dvd_q[30:0], 1'b0};
		end
	end

	// add / subtract
	logic [31:0] opd, ain;
	logic        cin, set_ca, ov_upd, ovf;
	logic [32:0] sum;
	logic [31:0] res;
	always_comb begin
		opd = b_q;
		if (op_q == ixa_pkg::OP_ADDME || op_q == ixa_pkg::OP_SUBFME) opd = '1;
		if (op_q == ixa_pkg::OP_ADDZE || op_q == ixa_pkg::OP_SUBFZE) opd = '0;
		ain = is_sub ? ~a_q : a_q;
		cin = 1'b0;
		if (op_q == ixa_pkg::OP_SUBF || op_q == ixa_pkg::OP_SUBFC) cin = 1'b1;
		else if ((is_add && op_q != ixa_pkg::OP_ADD && op_q != ixa_pkg::OP_ADDC) ||
			is_sub) cin = ca_q;
		sum = {1'b0, ain} + {1'b0, opd} + {32'd0, cin};
		set_ca = (is_add && op_q != ixa_pkg::OP_ADD) ||
			(is_sub && op_q != ixa_pkg::OP_SUBF);
		ov_upd = oe_q && op_q != ixa_pkg::OP_MULHW && op_q != ixa_pkg::OP_MULHWU;
		res = sum[31:0];
		ovf = (ain[31] == opd[31]) && (sum[31] != ain[31]);
		case (op_q)
			ixa_pkg::OP_NEG: begin
				res = 32'(-a_q);
				ovf = a_q == 32'h8000_0000;
			end
			ixa_pkg::OP_MULLW: begin
				res = prod_q[31:0];
				ovf = prod_q[63:32] != {32{prod_q[31]}};
			end
			ixa_pkg::OP_MULHW, ixa_pkg::OP_MULHWU: begin
				res = prod_q[63:32];
				ovf = 1'b0;
			end
			ixa_pkg::OP_DIVW: begin
				ovf = b_q == '0 || (a_q == 32'h8000_0000 && b_q == '1);
				res = ovf ? {32{a_q[31]}} : (neg_q ? 32'(-quo_q) : quo_q);
			end
			ixa_pkg::OP_DIVWU: begin
				ovf = b_q == '0;
				res = ovf ? 32'd0 : quo_q;
			end
			default: ;
		endcase
	end

	// flag state and result registers
	logic so_n;
	assign so_n = so_q | (ov_upd & ovf);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ca_q <= 1'b0; ov_q <= 1'b0; so_q <= 1'b0;
		end else if (cmd.finish && legal) begin
			if (set_ca) ca_q <= sum[32];
			if (ov_upd) begin
				ov_q <= ovf;
				so_q <= so_n;
			end
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			result <= legal ? res : '0;
			write_valid <= legal;
			illegal <= !legal;
			cr0_valid <= legal && rc_q;
			if (legal && rc_q)
				cr0_value <= {res[31], !res[31] && res != '0, res == '0, so_n};
			else cr0_value <= '0;
		end
	end
	assign carry_out = ca_q;
	assign overflow_out = ov_q;
	assign summary_out = so_q;
endmodule

### hw/rtl/integer_xo_alu.sv
// ----------------------------------------------------------------------------
// integer_xo_alu
// powerpc xo-form integer alu with carry, overflow and summary flags
// ----------------------------------------------------------------------------
// usage: one input transaction (op, a_value, b_value, oe, rc) over in_valid and
// in_ready; one result transaction over out_valid and out_ready.
// sequence: add, subtract, negate and multiply forms go through decode and finish
// before out_valid; divides run the radix-2 divider, one quotient bit a cycle
// (decode, 32 steps, finish). one transaction is in flight at a time, so the
// next is accepted the cycle after the result is taken.
// reset clears carry, overflow and summary overflow and returns to idle.
// while the receiver stalls, the result holds and no new input is taken.
// flag outputs show the state after the instruction.
// ----------------------------------------------------------------------------
`include "integer_xo_alu_assert.svh"
module integer_xo_alu (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [8:0]  op,
	input  logic [31:0] a_value,
	input  logic [31:0] b_value,
	input  logic        oe,
	input  logic        rc,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] result,
	output logic        write_valid,
	output logic        carry_out,
	output logic        overflow_out,
	output logic        summary_out,
	output logic [3:0]  cr0_value,
	output logic        cr0_valid,
	output logic        illegal
);
	ixa_pkg::cmd_t  cmd;
	ixa_pkg::stat_t stat;

	ixa_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
		.stat, .cmd
	);

	ixa_dp u_dp (
		.clk, .arst_n, .cmd, .stat, .op, .a_value, .b_value, .oe, .rc,
		.result, .write_valid, .carry_out, .overflow_out, .summary_out,
		.cr0_value, .cr0_valid, .illegal
	);

	// checks
	`XO_ASSERT_IMP(a_excl, clk, arst_n, out_valid, !in_ready)
	`XO_ASSERT_IMP(a_illegal, clk, arst_n, out_valid && illegal, !write_valid && !cr0_valid)
	`XO_ASSERT_NEXT(a_so_sticky, clk, arst_n, summary_out, summary_out)
endmodule

### sim/tb_integer_xo_alu.sv
// ----------------------------------------------------------------------------
// tb_integer_xo_alu
// self-checking bench for the xo-form integer alu: a behavioural model of the
// xer flags predicts each result; randomised valid and ready gaps in phases
// ----------------------------------------------------------------------------
module tb_integer_xo_alu;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [8:0]  op;
		logic [31:0] a;
		logic [31:0] b;
		logic        oe;
		logic        rc;
	} instr_t;

	typedef struct packed {
		logic [31:0] result;
		logic        write_valid;
		logic        carry;
		logic        ovf;
		logic        so;
		logic [3:0]  cr0;
		logic        cr0_valid;
		logic        illegal;
	} alu_res_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_ready;
	logic [8:0]  op = '0;
	logic [31:0] a_value = '0;
	logic [31:0] b_value = '0;
	logic        oe = 0;
	logic        rc = 0;
	logic        out_valid;
	logic        out_ready = 0;
	logic [31:0] result;
	logic        write_valid;
	logic        carry_out;
	logic        overflow_out;
	logic        summary_out;
	logic [3:0]  cr0_value;
	logic        cr0_valid;
	logic        illegal;

	instr_t   pending_instrs[$];
	alu_res_t expected_results[$];
	logic     xer_ca = 0, xer_ov = 0, xer_so = 0;
	int       errors = 0;
	int       checked = 0;
	int       send_idle_pct = 0;
	int       recv_stall_pct = 0;
	int       hold_off = 0;
	bit       hold_req = 0;
	bit       hold_taken = 0;
	bit       cur_valid = 0;
	longint   cycles = 0;
	logic     in_ready_q = 0;

	localparam logic [8:0] ALL_OPS [16] = '{ixa_pkg::OP_ADD, ixa_pkg::OP_ADDC,
		ixa_pkg::OP_ADDE, ixa_pkg::OP_ADDME, ixa_pkg::OP_ADDZE, ixa_pkg::OP_SUBF,
		ixa_pkg::OP_SUBFC, ixa_pkg::OP_SUBFE, ixa_pkg::OP_SUBFME, ixa_pkg::OP_SUBFZE,
		ixa_pkg::OP_NEG, ixa_pkg::OP_MULLW, ixa_pkg::OP_MULHW, ixa_pkg::OP_MULHWU,
		ixa_pkg::OP_DIVW, ixa_pkg::OP_DIVWU};

	integer_xo_alu DUT (.*);

	always #1 clk = ~clk;

	// predict the outcome of one instruction and update the flag copy
	function automatic alu_res_t xo_execute(instr_t t);
		alu_res_t r;
		logic [63:0] wide;
		longint sa, sb, exact, q;
		logic [31:0] opd, cin;
		bit set_ca, ovf, ov_upd, legal;
		r = '0;
		sa = longint'($signed(t.a));
		sb = longint'($signed(t.b));
		wide = 0; exact = 0; set_ca = 0; ovf = 0; ov_upd = t.oe; legal = 1;
		case (t.op)
			ixa_pkg::OP_ADD, ixa_pkg::OP_ADDC, ixa_pkg::OP_ADDE, ixa_pkg::OP_ADDME,
			ixa_pkg::OP_ADDZE: begin
				opd = (t.op == ixa_pkg::OP_ADDME) ? 32'hFFFF_FFFF :
					(t.op == ixa_pkg::OP_ADDZE) ? 32'h0 : t.b;
				cin = (t.op == ixa_pkg::OP_ADDE || t.op == ixa_pkg::OP_ADDME ||
					t.op == ixa_pkg::OP_ADDZE) ? {31'd0, xer_ca} : 32'd0;
				wide = {32'h0, t.a} + {32'h0, opd} + {32'h0, cin};
				exact = sa + longint'($signed(opd)) + longint'(cin);
				set_ca = (t.op != ixa_pkg::OP_ADD);
			end
			ixa_pkg::OP_SUBF, ixa_pkg::OP_SUBFC, ixa_pkg::OP_SUBFE, ixa_pkg::OP_SUBFME,
			ixa_pkg::OP_SUBFZE: begin
				opd = (t.op == ixa_pkg::OP_SUBFME) ? 32'hFFFF_FFFF :
					(t.op == ixa_pkg::OP_SUBFZE) ? 32'h0 : t.b;
				cin = (t.op == ixa_pkg::OP_SUBF || t.op == ixa_pkg::OP_SUBFC) ? 32'd1 :
					{31'd0, xer_ca};
				wide = {32'h0, ~t.a} + {32'h0, opd} + {32'h0, cin};
				exact = -sa + longint'($signed(opd)) + longint'(cin) - 1;
				set_ca = (t.op != ixa_pkg::OP_SUBF);
			end
			ixa_pkg::OP_NEG: begin
				wide = {32'h0, 32'h0 - t.a};
				exact = -sa;
			end
			ixa_pkg::OP_MULLW: begin
				exact = sa * sb;
				wide = {32'h0, exact[31:0]};
			end
			ixa_pkg::OP_MULHW: begin
				q = sa * sb;
				wide = {32'h0, q[63:32]};
				ov_upd = 0;
			end
			ixa_pkg::OP_MULHWU: begin
				wide = ({32'h0, t.a} * {32'h0, t.b}) >> 32;
				ov_upd = 0;
			end
			ixa_pkg::OP_DIVW: begin
				ovf = (t.b == 0) || (t.a == 32'h8000_0000 && t.b == 32'hFFFF_FFFF);
				if (ovf) wide = t.a[31] ? 64'hFFFF_FFFF : 64'h0;
				else begin
					q = sa / sb;
					wide = {32'h0, q[31:0]};
				end
			end
			ixa_pkg::OP_DIVWU: begin
				ovf = (t.b == 0);
				wide = ovf ? 64'h0 : {32'h0, t.a / t.b};
			end
			default: legal = 0;
		endcase
		if (!legal) begin
			r.carry = xer_ca; r.ovf = xer_ov; r.so = xer_so; r.illegal = 1;
			return r;
		end
		if (set_ca) xer_ca = wide[32];
		if (ov_upd) begin
			if (exact > 64'sh7FFF_FFFF || exact < -64'sh8000_0000) ovf = 1;
			xer_ov = ovf;
			if (ovf) xer_so = 1;
		end
		r.result = wide[31:0];
		r.write_valid = 1;
		r.carry = xer_ca; r.ovf = xer_ov; r.so = xer_so;
		if (t.rc) begin
			r.cr0 = wide[31] ? 4'b1000 : (wide[31:0] != 0) ? 4'b0100 : 4'b0010;
			r.cr0[0] = xer_so;
			r.cr0_valid = 1;
		end
		return r;
	endfunction

	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 7))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'h7FFF_FFFF;
			4: return $urandom_range(0, 15);
			5: return 32'hFFFF_FFFF - $urandom_range(0, 15);
			default: return $urandom;
		endcase
	endfunction

	function automatic instr_t random_instr();
		instr_t t;
		if ($urandom_range(0, 19) == 0) t.op = 9'($urandom);
		else t.op = ALL_OPS[$urandom_range(0, 15)];
		t.a = pick_operand();
		t.b = pick_operand();
		t.oe = 1'($urandom);
		t.rc = 1'($urandom);
		return t;
	endfunction

	// driver: present pending transactions, with random idle cycles
	always @(negedge clk) begin
		instr_t t;
		if (arst_n) begin
			if (cur_valid && in_ready_q) cur_valid = 0;
			if (!cur_valid && pending_instrs.size() > 0 &&
					$urandom_range(0, 99) >= send_idle_pct) begin
				t = pending_instrs.pop_front();
				op <= t.op; a_value <= t.a; b_value <= t.b; oe <= t.oe; rc <= t.rc;
				expected_results.push_back(xo_execute(t));
				cur_valid = 1;
			end
			in_valid <= cur_valid;
			out_ready <= (hold_off == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// acceptance seen at the rising edge, used by the driver on the next fall
	always @(posedge clk) in_ready_q <= in_valid && in_ready;

	// long receiver hold-off, started once on request and counted down here
	always @(posedge clk) begin
		if (hold_req && !hold_taken) begin
			hold_off <= 300;
			hold_taken <= 1;
		end else if (hold_off > 0) hold_off <= hold_off - 1;
	end

	// monitor: compare each result transaction with the oldest prediction
	always @(posedge clk) begin
		alu_res_t got, exp_r;
		cycles++;
		if (out_valid && out_ready) begin
			got = '{result, write_valid, carry_out, overflow_out, summary_out,
				cr0_value, cr0_valid, illegal};
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result transaction %h", $time, got);
				errors++;
			end else begin
				exp_r = expected_results.pop_front();
				checked++;
				if (got !== exp_r) begin
					$display("%0t: mismatch expected %h actual %h", $time, exp_r, got);
					errors++;
				end
			end
		end
		if (cycles > 2000000) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic instr_t mk(logic [8:0] o, logic [31:0] a, logic [31:0] b,
			logic e, logic r);
		instr_t t;
		t = '{o, a, b, e, r};
		return t;
	endfunction

	task automatic drain();
		wait (pending_instrs.size() == 0 && !cur_valid && expected_results.size() == 0);
		repeat (40) @(posedge clk);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1;

		// directed: every operation at the operand extremes, then special cases
		foreach (ALL_OPS[i])
			pending_instrs.push_back(mk(ALL_OPS[i], 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1, 1));
		pending_instrs.push_back(mk(ixa_pkg::OP_DIVW, 32'h8000_0000, 32'hFFFF_FFFF, 1, 1));
		pending_instrs.push_back(mk(ixa_pkg::OP_DIVW, 32'h8000_0000, 32'h0, 1, 1));
		pending_instrs.push_back(mk(ixa_pkg::OP_DIVW, 32'h5, 32'h0, 0, 1));
		pending_instrs.push_back(mk(ixa_pkg::OP_DIVWU, 32'hFFFF_FFFF, 32'h0, 1, 0));
		pending_instrs.push_back(mk(ixa_pkg::OP_MULHW, 32'h8000_0000, 32'h8000_0000, 1, 1));
		pending_instrs.push_back(mk(ixa_pkg::OP_ADDC, 32'hFFFF_FFFF, 32'h1, 0, 1));
		pending_instrs.push_back(mk(ixa_pkg::OP_ADDE, 32'h0, 32'h0, 0, 1));
		pending_instrs.push_back(mk(ixa_pkg::OP_NEG, 32'h8000_0000, 32'h0, 1, 1));
		pending_instrs.push_back(mk(9'h1FF, 32'h0, 32'h0, 1, 1));
		drain();

		// random phases: none, sender idle, receiver stall, both
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct  = (ph == 1) ? 75 : (ph == 3) ? 17 : 0;
			recv_stall_pct = (ph == 2) ? 75 : (ph == 3) ? 17 : 0;
			if (ph == 2) hold_req = 1;
			for (int n = 0; n < 250; n++) pending_instrs.push_back(random_instr());
			drain();
		end

		$display("covered %0d checked results over all opcodes, divide edge cases",
			checked);
		$display("and four handshake idling phases including a long receiver hold-off");
		if (errors == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end
endmodule
